// ----- rtl/gscc_pkg.sv -----
// Shared types and constants of the grid segment collision checker.
package gscc_pkg;

    // Default sizes
    localparam int GRID_SIDE_DEF = 256;
    localparam int MAX_STEPS_DEF = 1024;

    // Field widths
    localparam int RES_W  = 24;
    localparam int CELL_W = 9;
    localparam int CFG_IW = 3;

    // Configuration register indexes
    localparam logic [CFG_IW-1:0] REG_MAP_LOADED = 3'd0;
    localparam logic [CFG_IW-1:0] REG_CORNER_X   = 3'd1;
    localparam logic [CFG_IW-1:0] REG_CORNER_Y   = 3'd2;
    localparam logic [CFG_IW-1:0] REG_CELL_SIZE  = 3'd3;
    localparam logic [CFG_IW-1:0] REG_CELLS_X    = 3'd4;
    localparam logic [CFG_IW-1:0] REG_CELLS_Y    = 3'd5;

    // Item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Active configuration as seen by the sequencer
    typedef struct packed {
        logic               map_loaded;
        logic signed [31:0] corner_x;
        logic signed [31:0] corner_y;
        logic [RES_W-1:0]   res;       // cell size, zero already mapped to one
        logic [CELL_W-1:0]  cells_x;
        logic [CELL_W-1:0]  cells_y;
    } cfg_t;

    // Classified item held in the queue
    typedef struct packed {
        logic               kind;
        logic               wr_ok;     // cell inside the store
        logic               occupied;  // nonzero cost
        logic [7:0]         col;
        logic [7:0]         row;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
    } item_t;

endpackage

// ----- rtl/gscc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module gscc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/gscc_front.sv -----
// Input side: accepts items, classifies them and queues them for the sequencer.
module gscc_front #(
    parameter int GRID_SIDE = gscc_pkg::GRID_SIDE_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clearing,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_kind,
    input  logic [7:0]          s_cell_col,
    input  logic [7:0]          s_cell_row,
    input  logic [7:0]          s_cell_cost,
    input  logic signed [31:0]  s_start_x,
    input  logic signed [31:0]  s_start_y,
    input  logic signed [31:0]  s_end_x,
    input  logic signed [31:0]  s_end_y,
    output logic                head_valid,
    output gscc_pkg::item_t     head,
    input  logic                pop
);
    import gscc_pkg::*;

    item_t       ent_reg [2];
    logic        wptr_reg, wptr_next;
    logic        rptr_reg, rptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    item_t       cls;
    logic        push;

    // Classify the incoming item
    always_comb begin
        cls.kind     = s_kind;
        cls.wr_ok    = ({24'b0, s_cell_col} < 32'(GRID_SIDE)) &&
                       ({24'b0, s_cell_row} < 32'(GRID_SIDE));
        cls.occupied = (s_cell_cost != 8'd0);
        cls.col      = s_cell_col;
        cls.row      = s_cell_row;
        cls.sx       = s_start_x;
        cls.sy       = s_start_y;
        cls.ex       = s_end_x;
        cls.ey       = s_end_y;
    end

    assign s_ready    = (cnt_reg != 2'd2) && !clearing;
    assign push       = s_valid && s_ready;
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = ent_reg[rptr_reg];

    // Queue pointers
    always_comb begin
        wptr_next = wptr_reg ^ push;
        rptr_next = rptr_reg ^ pop;
        cnt_next  = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk) begin
        if (push) begin
            ent_reg[wptr_reg] <= cls;
        end
    end

endmodule

// ----- rtl/gscc_back.sv -----
// Back end: sequencer that runs cell writes and segment queries against the grid.
module gscc_back #(
    parameter int GRID_SIDE = gscc_pkg::GRID_SIDE_DEF,
    parameter int MAX_STEPS = gscc_pkg::MAX_STEPS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  gscc_pkg::cfg_t  cfg,
    input  logic            head_valid,
    input  gscc_pkg::item_t head,
    output logic            pop,
    output logic            clearing,
    output logic            m_valid,
    input  logic            m_ready,
    output logic            m_collides
);
    import gscc_pkg::*;

    localparam int DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int LOG   = $clog2(GRID_SIDE);
    localparam int LW    = LOG + RES_W + 1;
    localparam int SW    = $clog2(MAX_STEPS + 1);

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_SQ     = 4'd2;
    localparam logic [3:0] ST_ROOT   = 4'd3;
    localparam logic [3:0] ST_PT_SUB = 4'd4;
    localparam logic [3:0] ST_PT_DIV = 4'd5;
    localparam logic [3:0] ST_PT_RD  = 4'd6;
    localparam logic [3:0] ST_PT_CHK = 4'd7;
    localparam logic [3:0] ST_STEPS  = 4'd8;
    localparam logic [3:0] ST_UMUL   = 4'd9;
    localparam logic [3:0] ST_UDIV   = 4'd10;
    localparam logic [3:0] ST_ADV    = 4'd11;

    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    item_t         item_reg, item_next;
    logic          sgnx_reg, sgnx_next, sgny_reg, sgny_next;
    logic [32:0]   ax_reg, ax_next, ay_reg, ay_next;
    logic [65:0]   sa_reg, sa_next, sb_reg, sb_next;
    logic [32:0]   qa_reg, qa_next, qb_reg, qb_next;
    logic [65:0]   acc_reg, acc_next;
    logic [34:0]   rem_reg, rem_next;
    logic [32:0]   root_reg, root_next;
    logic [32:0]   len_reg, len_next;
    logic [6:0]    cnt_reg, cnt_next;
    logic [33:0]   px_reg, px_next, py_reg, py_next;
    logic          endp_reg, endp_next;
    logic [LW-1:0] remx_reg, remx_next, remy_reg, remy_next, dv_reg, dv_next;
    logic [LOG-1:0] qx_reg, qx_next, qy_reg, qy_next;
    logic [33:0]   num_reg, num_next;
    logic [24:0]   drem_reg, drem_next;
    logic [23:0]   mres_reg, mres_next;
    logic [56:0]   pa_reg, pa_next, pb_reg, pb_next;
    logic [32:0]   ra_reg, ra_next, rb_reg, rb_next;
    logic [24:0]   ux_reg, ux_next, uy_reg, uy_next;
    logic [SW-1:0] left_reg, left_next;
    logic          ov_reg, ov_next, oc_reg, oc_next;

    logic          ram_we, ram_wdata, ram_re, ram_rdata;
    logic [AW-1:0] ram_waddr, ram_raddr;

    logic [LOG:0]  lx, ly;
    logic [LW-1:0] lim_x, lim_y;
    logic [32:0]   dx, dy;
    logic [36:0]   rsh, trial;
    logic [34:0]   rx, ry;
    logic          bx, by;
    logic [24:0]   ssh;
    logic [33:0]   dsa, dsb;
    logic [23:0]   qux, quy;

    // Grid bounds in use and their extent in world units
    always_comb begin
        lx    = (LOG+1)'(({23'b0, cfg.cells_x} > 32'(GRID_SIDE)) ?
                         32'(GRID_SIDE) : {23'b0, cfg.cells_x});
        ly    = (LOG+1)'(({23'b0, cfg.cells_y} > 32'(GRID_SIDE)) ?
                         32'(GRID_SIDE) : {23'b0, cfg.cells_y});
        lim_x = LW'(lx) * LW'(cfg.res);
        lim_y = LW'(ly) * LW'(cfg.res);
    end

    gscc_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign clearing   = (state_reg == ST_CLEAR);
    assign m_valid    = ov_reg;
    assign m_collides = oc_reg;

    // Sequencer
    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        item_next  = item_reg;
        sgnx_next  = sgnx_reg;
        sgny_next  = sgny_reg;
        ax_next    = ax_reg;
        ay_next    = ay_reg;
        sa_next    = sa_reg;
        sb_next    = sb_reg;
        qa_next    = qa_reg;
        qb_next    = qb_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        endp_next  = endp_reg;
        remx_next  = remx_reg;
        remy_next  = remy_reg;
        dv_next    = dv_reg;
        qx_next    = qx_reg;
        qy_next    = qy_reg;
        num_next   = num_reg;
        drem_next  = drem_reg;
        mres_next  = mres_reg;
        pa_next    = pa_reg;
        pb_next    = pb_reg;
        ra_next    = ra_reg;
        rb_next    = rb_reg;
        ux_next    = ux_reg;
        uy_next    = uy_reg;
        left_next  = left_reg;
        ov_next    = ov_reg;
        oc_next    = oc_reg;
        pop        = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = clr_reg;
        ram_wdata  = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = AW'(32'(qy_reg) * 32'(GRID_SIDE) + 32'(qx_reg));
        dx         = {head.ex[31], head.ex} - {head.sx[31], head.sx};
        dy         = {head.ey[31], head.ey} - {head.sy[31], head.sy};
        rsh        = {rem_reg, acc_reg[65:64]};
        trial      = {2'b00, root_reg, 2'b01};
        rx         = {px_reg[33], px_reg} - {{3{cfg.corner_x[31]}}, cfg.corner_x};
        ry         = {py_reg[33], py_reg} - {{3{cfg.corner_y[31]}}, cfg.corner_y};
        bx         = 1'b0;
        by         = 1'b0;
        ssh        = {drem_reg[23:0], num_reg[33]};
        dsa        = {ra_reg, pa_reg[56]};
        dsb        = {rb_reg, pb_reg[56]};
        qux        = 24'd0;
        quy        = 24'd0;

        // Result register drains independently
        if (ov_reg && m_ready) begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            // Clear every grid cell after reset
            ST_CLEAR: begin
                ram_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end

            // Take the next item; queries wait for a free result register
            ST_IDLE: begin
                if (head_valid && head.kind == KIND_WRITE) begin
                    pop       = 1'b1;
                    ram_we    = head.wr_ok;
                    ram_waddr = AW'(32'(head.row) * 32'(GRID_SIDE) + 32'(head.col));
                    ram_wdata = head.occupied;
                end else if (head_valid && !ov_reg) begin
                    pop       = 1'b1;
                    item_next = head;
                    if (!cfg.map_loaded) begin
                        ov_next = 1'b1;
                        oc_next = 1'b0;
                    end else begin
                        sgnx_next  = dx[32];
                        sgny_next  = dy[32];
                        ax_next    = dx[32] ? (33'd0 - dx) : dx;
                        ay_next    = dy[32] ? (33'd0 - dy) : dy;
                        sa_next    = 66'(ax_next);
                        sb_next    = 66'(ay_next);
                        qa_next    = ax_next;
                        qb_next    = ay_next;
                        acc_next   = 66'd0;
                        cnt_next   = 7'd0;
                        state_next = ST_SQ;
                    end
                end
            end

            // dx^2 + dy^2 by shift and add
            ST_SQ: begin
                acc_next = acc_reg + (qa_reg[0] ? sa_reg : 66'd0)
                                   + (qb_reg[0] ? sb_reg : 66'd0);
                sa_next  = {sa_reg[64:0], 1'b0};
                sb_next  = {sb_reg[64:0], 1'b0};
                qa_next  = {1'b0, qa_reg[32:1]};
                qb_next  = {1'b0, qb_reg[32:1]};
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd32) begin
                    rem_next   = 35'd0;
                    root_next  = 33'd0;
                    cnt_next   = 7'd0;
                    state_next = ST_ROOT;
                end
            end

            // Integer square root, one result bit per cycle
            ST_ROOT: begin
                if (rsh >= trial) begin
                    rem_next  = 35'(rsh - trial);
                    root_next = {root_reg[31:0], 1'b1};
                end else begin
                    rem_next  = 35'(rsh);
                    root_next = {root_reg[31:0], 1'b0};
                end
                acc_next = {acc_reg[63:0], 2'b00};
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd32) begin
                    len_next   = root_next;
                    px_next    = {{2{item_reg.ex[31]}}, item_reg.ex};
                    py_next    = {{2{item_reg.ey[31]}}, item_reg.ey};
                    endp_next  = 1'b1;
                    state_next = ST_PT_SUB;
                end
            end

            // Point against the map bounds
            ST_PT_SUB: begin
                if (rx[34] || ry[34] ||
                    ({29'b0, rx} >= 64'(lim_x)) || ({29'b0, ry} >= 64'(lim_y))) begin
                    ov_next    = 1'b1;
                    oc_next    = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    remx_next  = LW'(rx);
                    remy_next  = LW'(ry);
                    dv_next    = LW'(cfg.res) << (LOG - 1);
                    qx_next    = '0;
                    qy_next    = '0;
                    cnt_next   = 7'd0;
                    state_next = ST_PT_DIV;
                end
            end

            // Cell index, one quotient bit per cycle on both axes
            ST_PT_DIV: begin
                bx = (remx_reg >= dv_reg);
                by = (remy_reg >= dv_reg);
                if (bx) begin
                    remx_next = remx_reg - dv_reg;
                end
                if (by) begin
                    remy_next = remy_reg - dv_reg;
                end
                qx_next  = LOG'({qx_reg, bx});
                qy_next  = LOG'({qy_reg, by});
                dv_next  = dv_reg >> 1;
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'(LOG - 1)) begin
                    state_next = ST_PT_RD;
                end
            end

            ST_PT_RD: begin
                ram_re     = 1'b1;
                state_next = ST_PT_CHK;
            end

            // Occupancy of the cell; after the endpoint, end a segment shorter than one cell or set up the sampling
            ST_PT_CHK: begin
                if (ram_rdata) begin
                    ov_next    = 1'b1;
                    oc_next    = 1'b1;
                    state_next = ST_IDLE;
                end else if (!endp_reg) begin
                    state_next = ST_ADV;
                end else if (len_reg < {9'b0, cfg.res}) begin
                    ov_next    = 1'b1;
                    oc_next    = 1'b0;
                    state_next = ST_IDLE;
                end else begin
                    num_next   = {1'b0, len_reg} + {10'b0, cfg.res} - 34'd1;
                    drem_next  = 25'd0;
                    cnt_next   = 7'd0;
                    state_next = ST_STEPS;
                end
            end

            // Sample count = ceil(len / res), capped
            ST_STEPS: begin
                bx = (ssh >= {1'b0, cfg.res});
                drem_next = bx ? (ssh - {1'b0, cfg.res}) : ssh;
                num_next  = {num_reg[32:0], bx};
                cnt_next  = cnt_reg + 7'd1;
                if (cnt_reg == 7'd33) begin
                    left_next  = (num_next > 34'(MAX_STEPS)) ? SW'(MAX_STEPS - 1) :
                                 SW'(num_next - 34'd1);
                    sa_next    = 66'(ax_reg);
                    sb_next    = 66'(ay_reg);
                    mres_next  = cfg.res;
                    pa_next    = 57'd0;
                    pb_next    = 57'd0;
                    cnt_next   = 7'd0;
                    state_next = ST_UMUL;
                end
            end

            // |d| * res by shift and add
            ST_UMUL: begin
                pa_next   = pa_reg + (mres_reg[0] ? sa_reg[56:0] : 57'd0);
                pb_next   = pb_reg + (mres_reg[0] ? sb_reg[56:0] : 57'd0);
                sa_next   = {sa_reg[64:0], 1'b0};
                sb_next   = {sb_reg[64:0], 1'b0};
                mres_next = {1'b0, mres_reg[23:1]};
                cnt_next  = cnt_reg + 7'd1;
                if (cnt_reg == 7'd23) begin
                    ra_next    = 33'd0;
                    rb_next    = 33'd0;
                    cnt_next   = 7'd0;
                    state_next = ST_UDIV;
                end
            end

            // Unit step = |d| * res / len, restoring division on both axes
            ST_UDIV: begin
                bx = (dsa >= {1'b0, len_reg});
                by = (dsb >= {1'b0, len_reg});
                ra_next  = 33'(bx ? (dsa - {1'b0, len_reg}) : dsa);
                rb_next  = 33'(by ? (dsb - {1'b0, len_reg}) : dsb);
                pa_next  = {pa_reg[55:0], bx};
                pb_next  = {pb_reg[55:0], by};
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd56) begin
                    qux        = pa_next[23:0];
                    quy        = pb_next[23:0];
                    ux_next    = sgnx_reg ? (25'd0 - {1'b0, qux}) : {1'b0, qux};
                    uy_next    = sgny_reg ? (25'd0 - {1'b0, quy}) : {1'b0, quy};
                    px_next    = {{2{item_reg.sx[31]}}, item_reg.sx};
                    py_next    = {{2{item_reg.sy[31]}}, item_reg.sy};
                    endp_next  = 1'b0;
                    state_next = ST_ADV;
                end
            end

            // Step to the next sample or finish clear
            ST_ADV: begin
                if (left_reg == '0) begin
                    ov_next    = 1'b1;
                    oc_next    = 1'b0;
                    state_next = ST_IDLE;
                end else begin
                    px_next    = px_reg + {{9{ux_reg[24]}}, ux_reg};
                    py_next    = py_reg + {{9{uy_reg[24]}}, uy_reg};
                    left_next  = left_reg - 1'b1;
                    state_next = ST_PT_SUB;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk) begin
        if (!rst_n) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk) begin
        item_reg <= item_next;
        sgnx_reg <= sgnx_next;
        sgny_reg <= sgny_next;
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        sa_reg   <= sa_next;
        sb_reg   <= sb_next;
        qa_reg   <= qa_next;
        qb_reg   <= qb_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        len_reg  <= len_next;
        cnt_reg  <= cnt_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        endp_reg <= endp_next;
        remx_reg <= remx_next;
        remy_reg <= remy_next;
        dv_reg   <= dv_next;
        qx_reg   <= qx_next;
        qy_reg   <= qy_next;
        num_reg  <= num_next;
        drem_reg <= drem_next;
        mres_reg <= mres_next;
        pa_reg   <= pa_next;
        pb_reg   <= pb_next;
        ra_reg   <= ra_next;
        rb_reg   <= rb_next;
        ux_reg   <= ux_next;
        uy_reg   <= uy_next;
        left_reg <= left_next;
        oc_reg   <= oc_next;
    end

endmodule

// ----- rtl/grid_segment_collision_check.sv -----
// Query: taken from the queue, then squares, square root and an endpoint check; with
// sampling, step count, unit step (multiply, then divide), a check per sample (up to
// MAX_STEPS-1) and a closing step, all run by one bit-serial sequencer and one read port.
// Cell write: done by the sequencer while idle. A two-entry queue buffers inputs meanwhile.
// Reset: synchronous, active low; control registers take their defaults, then a clearing pass
// over all GRID_SIDE*GRID_SIDE cells (65536 by default) frees every cell while s_ready is low.
module grid_segment_collision_check #(
    parameter int GRID_SIDE = gscc_pkg::GRID_SIDE_DEF,
    parameter int MAX_STEPS = gscc_pkg::MAX_STEPS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_kind,
    input  logic [7:0]                  s_cell_col,
    input  logic [7:0]                  s_cell_row,
    input  logic [7:0]                  s_cell_cost,
    input  logic signed [31:0]          s_start_x,
    input  logic signed [31:0]          s_start_y,
    input  logic signed [31:0]          s_end_x,
    input  logic signed [31:0]          s_end_y,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_collides,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [gscc_pkg::CFG_IW-1:0] cfg_index,
    input  logic [31:0]                 cfg_data
);
    import gscc_pkg::*;

    logic               map_loaded_reg;
    logic signed [31:0] corner_x_reg, corner_y_reg;
    logic [RES_W-1:0]   cell_size_reg;
    logic [CELL_W-1:0]  cells_x_reg, cells_y_reg;
    cfg_t               cfg;
    item_t              head;
    logic               head_valid, pop, clearing;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_loaded_reg <= 1'b0;
            corner_x_reg   <= '0;
            corner_y_reg   <= '0;
            cell_size_reg  <= RES_W'(3277);
            cells_x_reg    <= CELL_W'(256);
            cells_y_reg    <= CELL_W'(256);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_MAP_LOADED: map_loaded_reg <= cfg_data[0];
                REG_CORNER_X:   corner_x_reg   <= cfg_data;
                REG_CORNER_Y:   corner_y_reg   <= cfg_data;
                REG_CELL_SIZE:  cell_size_reg  <= cfg_data[RES_W-1:0];
                REG_CELLS_X:    cells_x_reg    <= cfg_data[CELL_W-1:0];
                REG_CELLS_Y:    cells_y_reg    <= cfg_data[CELL_W-1:0];
                default: ;
            endcase
        end
    end

    // Zero cell size acts as one
    always_comb begin
        cfg.map_loaded = map_loaded_reg;
        cfg.corner_x   = corner_x_reg;
        cfg.corner_y   = corner_y_reg;
        cfg.res        = (cell_size_reg == '0) ? RES_W'(1) : cell_size_reg;
        cfg.cells_x    = cells_x_reg;
        cfg.cells_y    = cells_y_reg;
    end

    gscc_front #(.GRID_SIDE(GRID_SIDE)) u_front (
        .clk        (aclk),
        .rst_n      (aresetn),
        .clearing   (clearing),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_kind     (s_kind),
        .s_cell_col (s_cell_col),
        .s_cell_row (s_cell_row),
        .s_cell_cost(s_cell_cost),
        .s_start_x  (s_start_x),
        .s_start_y  (s_start_y),
        .s_end_x    (s_end_x),
        .s_end_y    (s_end_y),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    gscc_back #(.GRID_SIDE(GRID_SIDE), .MAX_STEPS(MAX_STEPS)) u_back (
        .clk        (aclk),
        .rst_n      (aresetn),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .clearing   (clearing),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_collides (m_collides)
    );

endmodule
